// File: rtl/rwm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rwm_pkg
// Shared types and constants of the rolling window mean core.
// ----------------------------------------------------------------------------
package rwm_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int WIN_LEN_W  = 7;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [WIN_LEN_W-1:0] WIN_LEN_RESET = 7'd1;

  // Register index, taken from the word address bit of paddr.
  localparam logic REG_WINDOW_LENGTH = 1'b0;

  typedef struct packed {
    logic capture;
    logic prep;
    logic sub;
    logic add;
    logic div_load;
    logic div_step;
    logic load_out;
  } rwm_cmd_t;

  typedef struct packed {
    logic len_zero;
    logic window_full;
  } rwm_sts_t;

endpackage
`default_nettype wire

// File: rtl/rwm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rwm_ctrl
// Sequencer: takes one sample, walks the window update, runs the divider
// steps once the window is full and hands the result to the output register.
// ----------------------------------------------------------------------------
module rwm_ctrl
  import rwm_pkg::*;
#(
  parameter int SUM_W = 38
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  input  wire logic     out_tready,
  output logic          out_tvalid,
  input  wire rwm_sts_t sts,
  output rwm_cmd_t      cmd
);

  localparam int CNT_W = $clog2(SUM_W);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PREP = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_SUB  = 3'd3;
  localparam logic [2:0] ST_ADD  = 3'd4;
  localparam logic [2:0] ST_CHK  = 3'd5;
  localparam logic [2:0] ST_DIV  = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = sts.len_zero ? ST_IDLE : ST_RD;
      end
      ST_RD: begin
        state_nxt = ST_SUB;
      end
      ST_SUB: begin
        cmd.sub   = 1'b1;
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        if (sts.window_full) begin
          cmd.div_load = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = ST_DIV;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(SUM_W - 1)) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/rwm_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rwm_datapath
// Window store, pointer, fill count, running sum, window length register,
// bit-serial divider and result register.
// ----------------------------------------------------------------------------
module rwm_datapath
  import rwm_pkg::*;
#(
  parameter int MAX_WINDOW = 64,
  parameter int SUM_W      = 38
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire rwm_cmd_t                    cmd,
  output rwm_sts_t                         sts,
  input  wire logic signed [SAMPLE_W-1:0]  in_sample,
  input  wire logic                        in_start,
  input  wire logic                        cfg_we,
  input  wire logic [WIN_LEN_W-1:0]        cfg_wdata,
  output logic [WIN_LEN_W-1:0]             win_len,
  output logic [SAMPLE_W-1:0]              mean
);

  localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int IDX_W = (PTR_W + 1 > WIN_LEN_W) ? PTR_W + 1 : WIN_LEN_W;

  logic signed [SAMPLE_W-1:0] mem [MAX_WINDOW];

  logic [WIN_LEN_W-1:0]       wl_r;
  logic [PTR_W-1:0]           ptr_r, ptr_nxt;
  logic [WIN_LEN_W-1:0]       fill_r, fill_nxt;
  logic signed [SUM_W-1:0]    sum_r, sum_nxt;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic                       start_r;
  logic signed [SAMPLE_W-1:0] rd_data_r;
  logic [SUM_W-1:0]           quo_r;
  logic [WIN_LEN_W:0]         rem_r;
  logic                       neg_r;
  logic [SAMPLE_W-1:0]        mean_r;

  logic [WIN_LEN_W-1:0]       n;
  logic [IDX_W-1:0]           ptr_inc;
  logic [WIN_LEN_W:0]         rem_sh;
  logic                       rem_ge;
  logic [SUM_W-1:0]           quo_signed;

  assign n = (32'(wl_r) > 32'(MAX_WINDOW)) ? WIN_LEN_W'(MAX_WINDOW) : wl_r;

  assign sts.len_zero    = (n == '0);
  assign sts.window_full = (fill_r >= n);
  assign win_len         = wl_r;
  assign mean            = mean_r;

  assign ptr_inc = IDX_W'(ptr_r) + 1'b1;

  always_comb begin
    ptr_nxt  = ptr_r;
    fill_nxt = fill_r;
    sum_nxt  = sum_r;
    if (cfg_we) begin
      ptr_nxt  = '0;
      fill_nxt = '0;
      sum_nxt  = '0;
    end else if (cmd.prep) begin
      if (start_r) begin
        fill_nxt = '0;
        sum_nxt  = '0;
      end
      if (start_r || (IDX_W'(ptr_r) >= IDX_W'(n))) begin
        ptr_nxt = '0;
      end
    end else if (cmd.sub) begin
      if (fill_r >= n) begin
        sum_nxt = sum_r - SUM_W'(rd_data_r);
      end
    end else if (cmd.add) begin
      sum_nxt = sum_r + SUM_W'(sample_r);
      ptr_nxt = (ptr_inc == IDX_W'(n)) ? '0 : PTR_W'(ptr_inc);
      if (fill_r < n) begin
        fill_nxt = fill_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r   <= WIN_LEN_RESET;
      ptr_r  <= '0;
      fill_r <= '0;
      sum_r  <= '0;
    end else begin
      if (cfg_we) begin
        wl_r <= cfg_wdata;
      end
      ptr_r  <= ptr_nxt;
      fill_r <= fill_nxt;
      sum_r  <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add) begin
      mem[ptr_r] <= sample_r;
    end
    rd_data_r <= mem[ptr_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_r <= in_sample;
      start_r  <= in_start;
    end
  end

  assign rem_sh     = {rem_r[WIN_LEN_W-1:0], quo_r[SUM_W-1]};
  assign rem_ge     = (rem_sh >= {1'b0, n});
  assign quo_signed = neg_r ? (~quo_r + 1'b1) : quo_r;

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      neg_r <= sum_r[SUM_W-1];
      quo_r <= sum_r[SUM_W-1] ? unsigned'(-sum_r) : unsigned'(sum_r);
      rem_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= rem_ge ? (rem_sh - {1'b0, n}) : rem_sh;
      quo_r <= {quo_r[SUM_W-2:0], rem_ge};
    end
    if (cmd.load_out) begin
      mean_r <= quo_signed[SAMPLE_W-1:0];
    end
  end

endmodule
`default_nettype wire

// File: rtl/rolling_window_mean_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rolling_window_mean_core
// Moving average of signed Q16.16 samples over a programmable window.
//
// Channel  Direction  Handshake          Payload
// in_      slave      tvalid / tready    tdata: sample; tuser: series_start
// out_     master     tvalid / tready    tdata: mean
// cfg_     APB        psel / penable     window_length at address 0
//
// A sample that yields a mean passes through the PREP, RD, SUB, ADD and CHK
// states, the divider steps and OUT before the next input transfer; the
// divider produces one quotient bit per cycle. A sample that only fills the
// window returns to idle after CHK; with a zero window length it returns
// after PREP. Reset clears the window and sets the length to 1.
// A stalled result waits in the output register while the next sample is
// taken; the divider holds its quotient until that register frees up.
// ----------------------------------------------------------------------------
module rolling_window_mean_core
  import rwm_pkg::*;
#(
  parameter int MAX_WINDOW = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [31:0]           in_tdata,   // [31:0] sample
  input  wire logic                  in_tuser,   // [0] series_start
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [31:0]                out_tdata,  // [31:0] mean
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0]      cfg_prdata,
  output logic                       cfg_pready
);

  localparam int SUM_W = SAMPLE_W + $clog2(MAX_WINDOW);

  rwm_cmd_t             cmd;
  rwm_sts_t             sts;
  logic                 cfg_we;
  logic [WIN_LEN_W-1:0] win_len;

  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr[2] == REG_WINDOW_LENGTH);
  assign cfg_prdata = (cfg_paddr[2] == REG_WINDOW_LENGTH) ?
                      CFG_DATA_W'(win_len) : '0;

  rwm_ctrl #(
    .SUM_W(SUM_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .sts        (sts),
    .cmd        (cmd)
  );

  rwm_datapath #(
    .MAX_WINDOW (MAX_WINDOW),
    .SUM_W      (SUM_W)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_sample  (signed'(in_tdata)),
    .in_start   (in_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_pwdata[WIN_LEN_W-1:0]),
    .win_len    (win_len),
    .mean       (out_tdata)
  );

endmodule
`default_nettype wire

// File: rtl/rwm_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rwm_checker
// Port-level checks of the rolling window mean core.
// ----------------------------------------------------------------------------
module rwm_checker
  import rwm_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [31:0]           out_tdata,
  input wire logic                  cfg_pready
);

  // A held result keeps its value until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

  // The core works on one sample at a time.
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second sample taken while busy");

  // A sample cannot produce its mean in the cycle after its transfer.
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !$rose(out_tvalid))
    else $error("result appeared too early");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("configuration port not ready");

endmodule

bind rolling_window_mean_core rwm_checker u_rwm_checker (.*);
`default_nettype wire
